@@ rtl/core/mvcm_pkg.sv @@
`timescale 1ns / 1ps
package mvcm_pkg;

	localparam int NUM_VOICES_DEF  = 8;
	localparam int CLIP_FRAMES_DEF = 2048;

	localparam logic signed [15:0] SAT_MAX = 16'sd32767;
	localparam logic signed [15:0] SAT_MIN = -16'sd32768;

	localparam logic [1:0] CH_MONO  = 2'd1;
	localparam logic [1:0] CH_RESET = 2'd2;

	// request codes
	typedef enum logic [2:0] {
		REQ_WRITE    = 3'd0,
		REQ_SET_LEN  = 3'd1,
		REQ_PLAY     = 3'd2,
		REQ_STOP     = 3'd3,
		REQ_STOP_ALL = 3'd4,
		REQ_RENDER   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAIT
	} state_t;

	// command broadcast to every cell
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  voice;
		logic [10:0] frame;
		logic [11:0] frames;
		logic [31:0] word;
	} cmd_t;

	// 16 bit saturating add
	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [16:0] s;
		s = 17'(a) + 17'(b);
		if (s > 17'(SAT_MAX))
			return SAT_MAX;
		else if (s < 17'(SAT_MIN))
			return SAT_MIN;
		else
			return s[15:0];
	endfunction

endpackage

@@ rtl/core/mvcm_cell.sv @@
`timescale 1ns / 1ps
module mvcm_cell import mvcm_pkg::*; #(
	parameter int CELL_ID     = 0,
	parameter int CLIP_FRAMES = CLIP_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_en,
	input  cmd_t               cmd,
	input  logic               stereo,
	input  logic               in_vld,
	input  logic signed [15:0] in_left,
	input  logic signed [15:0] in_right,
	output logic               out_vld,
	output logic signed [15:0] out_left,
	output logic signed [15:0] out_right,
	output logic               active
);

	localparam int AW = $clog2(CLIP_FRAMES);
	localparam int LW = $clog2(CLIP_FRAMES + 1);

	logic [31:0]        mem [CLIP_FRAMES];
	logic [31:0]        rd_q;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      pos_q;
	logic               act_q;
	logic               vld_s1;
	logic signed [15:0] left_s1;
	logic signed [15:0] right_s1;

	logic               hit;
	logic [31:0]        frame32;
	logic [31:0]        frames32;
	logic [LW-1:0]      len_new;
	logic [LW-1:0]      pos_inc;
	logic               playing;

	assign hit      = (32'(cmd.voice) == 32'(CELL_ID));
	assign frame32  = 32'(cmd.frame);
	assign frames32 = (32'(cmd.frames) > 32'(CLIP_FRAMES)) ? 32'(CLIP_FRAMES)
	                                                       : 32'(cmd.frames);
	assign len_new  = frames32[LW-1:0];
	assign pos_inc  = pos_q + LW'(1);
	assign playing  = act_q && (pos_q < len_q);

	// clip memory, read at the play position every cycle
	always_ff @(posedge clk) begin
		if (cmd_en && cmd.kind == REQ_WRITE && hit && frame32 < 32'(CLIP_FRAMES))
			mem[frame32[AW-1:0]] <= cmd.word;
		rd_q <= mem[pos_q[AW-1:0]];
	end

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pos_q <= '0;
			act_q <= 1'b0;
		end else if (cmd_en) begin
			case (cmd.kind)
				REQ_SET_LEN: if (hit) len_q <= len_new;
				REQ_PLAY: begin
					if (hit) begin
						act_q <= 1'b1;
						pos_q <= '0;
					end
				end
				REQ_STOP: if (hit) act_q <= 1'b0;
				REQ_STOP_ALL: act_q <= 1'b0;
				default: ;
			endcase
		end else if (in_vld && act_q) begin
			if (!playing) begin
				act_q <= 1'b0;
			end else begin
				pos_q <= pos_inc;
				if (pos_inc == len_q)
					act_q <= 1'b0;
			end
		end
	end

	// mix stage handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			left_s1  <= playing ? sat_add(in_left, rd_q[15:0]) : in_left;
			right_s1 <= (playing && stereo) ? sat_add(in_right, rd_q[31:16]) : in_right;
		end
	end

	assign out_vld   = vld_s1;
	assign out_left  = left_s1;
	assign out_right = right_s1;
	assign active    = act_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= 32'(CLIP_FRAMES)) else $error("clip length above capacity");
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_vld && !act_q) |=> $stable(pos_q)) else $error("idle voice moved");
	a_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |=> vld_s1) else $error("item lost in cell");

endmodule

@@ rtl/core/multi_voice_clip_mixer_unit.sv @@
`timescale 1ns / 1ps
// Clip mixer: a row of voice cells, each owning one clip memory, its length,
// play position and active flag. A render item enters the first cell and moves
// one cell per cycle, each active voice adding its current sample with 16 bit
// saturation; the result is registered when the item leaves the last cell, and
// other requests are applied in the execute state. One item is worked at a time,
// and a new item is taken once the previous result has been delivered.
module multi_voice_clip_mixer_unit import mvcm_pkg::*; #(
	parameter int NUM_VOICES  = NUM_VOICES_DEF,
	parameter int CLIP_FRAMES = CLIP_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [2:0]         voice_id,
	input  logic [10:0]        frame_index,
	input  logic [11:0]        clip_frames,
	input  logic signed [15:0] load_left,
	input  logic signed [15:0] load_right,
	input  logic signed [15:0] mix_left,
	input  logic signed [15:0] mix_right,
	input  logic               buffer_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_left,
	output logic signed [15:0] out_right,
	output logic               queried_active,
	output logic               any_active,
	output logic               buffer_end_out
);

	state_t             state_q, state_d;
	logic [1:0]         chan_q;
	cmd_t               cmd_q;
	logic signed [15:0] mixl_q, mixr_q;
	logic               bend_q;
	logic               ov_q;
	logic signed [15:0] ol_q, or_q;
	logic               oq_q, oa_q, ob_q;

	logic               stereo;
	logic               is_render;
	logic               cmd_en, tok_vld, done;
	logic               vld_c  [NUM_VOICES+1];
	logic signed [15:0] left_c [NUM_VOICES+1];
	logic signed [15:0] right_c[NUM_VOICES+1];
	logic [NUM_VOICES-1:0] act;
	logic               qa;

	assign stereo    = (chan_q != CH_MONO);
	assign is_render = (cmd_q.kind == REQ_RENDER);
	assign in_ready  = (state_q == ST_IDLE) && !ov_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chan_q <= CH_RESET;
		else if (cfg_we)
			chan_q <= cfg_wdata;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= '{kind: req_type, voice: voice_id, frame: frame_index,
			           frames: clip_frames, word: {load_right, load_left}};
			mixl_q <= mix_left;
			mixr_q <= mix_right;
			bend_q <= buffer_end;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd_en  = 1'b0;
		tok_vld = 1'b0;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) state_d = ST_EXEC;
			ST_EXEC: begin
				cmd_en  = !is_render;
				tok_vld = is_render;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				done = is_render ? vld_c[NUM_VOICES] : 1'b1;
				if (done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// chain of voice cells
	assign vld_c[0]   = tok_vld;
	assign left_c[0]  = mixl_q;
	assign right_c[0] = stereo ? mixr_q : 16'sd0;

	for (genvar v = 0; v < NUM_VOICES; v++) begin : g_cell
		mvcm_cell #(.CELL_ID(v), .CLIP_FRAMES(CLIP_FRAMES)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd_en   (cmd_en),
			.cmd      (cmd_q),
			.stereo   (stereo),
			.in_vld   (vld_c[v]),
			.in_left  (left_c[v]),
			.in_right (right_c[v]),
			.out_vld  (vld_c[v+1]),
			.out_left (left_c[v+1]),
			.out_right(right_c[v+1]),
			.active   (act[v])
		);
	end

	// flag of the addressed voice
	always_comb begin
		qa = 1'b0;
		for (int v = 0; v < NUM_VOICES; v++)
			if (32'(cmd_q.voice) == 32'(v) && act[v])
				qa = 1'b1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (done)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			ol_q <= is_render ? left_c[NUM_VOICES] : 16'sd0;
			or_q <= is_render ? right_c[NUM_VOICES] : 16'sd0;
			ob_q <= is_render && bend_q;
			oq_q <= qa;
			oa_q <= |act;
		end
	end

	assign out_valid      = ov_q;
	assign out_left       = ol_q;
	assign out_right      = or_q;
	assign queried_active = oq_q;
	assign any_active     = oa_q;
	assign buffer_end_out = ob_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_EXEC) else $error("accept not executed");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !ov_q) else $error("result overwritten");
	a_chain_wait: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c[NUM_VOICES] |-> state_q == ST_WAIT) else $error("chain item outside wait");

endmodule
